// ===== src/lru_mtf_pkg.sv =====
// shared types and constants for the move-to-front lru cache
// no dependencies; imported by lru_move_to_front_cache and its testbench
package lru_mtf_pkg;

    // list geometry and field widths
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEY_W  = 32;
    localparam int DATA_W = 64;
    localparam int OP_W   = 2;

    // packed stream words
    localparam int IN_TDATA_W  = KEY_W + DATA_W;
    localparam int OUT_BITS    = DATA_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // capacity register reset value
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    // operation codes carried in the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_GET   = 2'd0,
        OP_PUT   = 2'd1,
        OP_INVAL = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_DECIDE,
        S_DOWN_RD,
        S_DOWN_WR,
        S_FRONT,
        S_UP_RD,
        S_UP_WR,
        S_DONE
    } state_t;

endpackage

// ===== src/lru_mtf_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module lru_mtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== src/lru_move_to_front_cache.sv =====
// fully associative lru cache kept as a recency-ordered list
// depends on lru_mtf_pkg and lru_mtf_ram
//
// usage
//   input words arrive on s_axis: tuser holds the operation (get, put,
//   invalidate, clear), tdata the key and the data for a put. every word
//   gives exactly one result word on m_axis: tuser is the hit flag, tdata
//   holds the returned data and the entry count after the operation. the
//   user must write capacity (cfg_we / cfg_wdata) only while the block is
//   idle; the block itself does not enforce this.
// sequencing
//   one word at a time. the key search reads one list position at a time
//   (S_RD, S_CMP) through a single shared key comparator; moving an entry
//   to the front reads and writes each shifted position (S_DOWN_RD,
//   S_DOWN_WR), then writes the front (S_FRONT); closing a gap reads and
//   writes each position behind it (S_UP_RD, S_UP_WR). s_axis_tready is
//   high only while the sequencer is idle.
// reset and stalls
//   reset empties the list and sets capacity to 16; no clearing pass. a
//   finished result waits in the output register while m_axis_tready is
//   low; the next input word is still taken, and its result is held back
//   until the output register is free.
module lru_move_to_front_cache (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration: capacity
    input  logic                                  cfg_we,
    input  logic [lru_mtf_pkg::CNT_W-1:0]         cfg_wdata,
    // input words
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [lru_mtf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // key_tag, data_in
    input  logic [lru_mtf_pkg::OP_W-1:0]          s_axis_tuser,  // op
    // result words
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [lru_mtf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // data_out, entries_held, pad
    output logic                                  m_axis_tuser   // hit
);

    import lru_mtf_pkg::*;

    // control state
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic              hit_reg, hit_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  cap_reg;
    logic              out_valid_reg, out_valid_next;

    // payload
    op_t               op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [DATA_W-1:0] din_reg, din_next;
    logic [DATA_W-1:0] save_reg, save_next;
    logic              out_hit_reg, out_hit_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;

    // memory ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_raddr;
    logic [KEY_W-1:0]  key_wdata, key_rdata;
    logic [DATA_W-1:0] data_wdata, data_rdata;

    // helpers
    logic [CNT_W-1:0]  eff_cap;
    logic [CNT_W-1:0]  trimmed;
    logic [CNT_W-1:0]  idx_ext;
    logic              key_match;
    logic              in_fire;

    lru_mtf_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_wdata),
        .raddr (ram_raddr),
        .rdata (key_rdata)
    );

    lru_mtf_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_data_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (data_wdata),
        .raddr (ram_raddr),
        .rdata (data_rdata)
    );

    // capacity limits: zero acts as one, above depth acts as depth
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(DEPTH))
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = cap_reg;
        end
        trimmed = (fill_reg >= eff_cap) ? (eff_cap - CNT_W'(1)) : fill_reg;
    end

    assign idx_ext       = {1'b0, idx_reg};
    assign key_match     = (key_rdata == key_reg);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // sequencer: next state, memory control and result
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        hit_next       = hit_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        din_next       = din_reg;
        save_next      = save_reg;
        out_hit_next   = out_hit_reg;
        out_data_next  = out_data_reg;
        out_cnt_next   = out_cnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_raddr      = idx_reg;
        key_wdata      = key_rdata;
        data_wdata     = data_rdata;

        // result word taken downstream
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next   = op_t'(s_axis_tuser);
                    key_next  = s_axis_tdata[KEY_W-1:0];
                    din_next  = s_axis_tdata[KEY_W +: DATA_W];
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    save_next = '0;
                    state_next = (fill_reg == '0) ? S_DECIDE : S_RD;
                end
            end

            // issue read of the probed position
            S_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = S_CMP;
            end

            // compare against the shared key comparator
            S_CMP:
            begin
                if (key_match)
                begin
                    hit_next   = 1'b1;
                    pos_next   = idx_reg;
                    save_next  = data_rdata;
                    state_next = S_DECIDE;
                end
                else if (idx_ext + CNT_W'(1) == fill_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_RD;
                end
            end

            // choose the list update for the operation
            S_DECIDE:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_GET, OP_PUT:
                    begin
                        if (hit_reg)
                        begin
                            idx_next   = pos_reg;
                            state_next = (pos_reg == '0) ? S_FRONT : S_DOWN_RD;
                        end
                        else if (op_reg == OP_PUT)
                        begin
                            fill_next  = trimmed + CNT_W'(1);
                            idx_next   = trimmed[IDX_W-1:0];
                            state_next = (trimmed == '0) ? S_FRONT : S_DOWN_RD;
                        end
                    end
                    OP_INVAL:
                    begin
                        if (hit_reg)
                        begin
                            fill_next = fill_reg - CNT_W'(1);
                            idx_next  = pos_reg;
                            if ({1'b0, pos_reg} + CNT_W'(1) < fill_reg)
                            begin
                                state_next = S_UP_RD;
                            end
                        end
                    end
                    OP_CLEAR:
                    begin
                        fill_next = '0;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // shift towards the back: read the entry in front
            S_DOWN_RD:
            begin
                ram_raddr  = idx_reg - IDX_W'(1);
                state_next = S_DOWN_WR;
            end

            S_DOWN_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                if (idx_reg == IDX_W'(1))
                begin
                    state_next = S_FRONT;
                end
                else
                begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = S_DOWN_RD;
                end
            end

            // write the most recent entry at the front
            S_FRONT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                key_wdata  = key_reg;
                data_wdata = (op_reg == OP_PUT) ? din_reg : save_reg;
                state_next = S_DONE;
            end

            // close the gap: read the entry behind
            S_UP_RD:
            begin
                ram_raddr  = idx_reg + IDX_W'(1);
                state_next = S_UP_WR;
            end

            S_UP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                idx_next  = idx_reg + IDX_W'(1);
                if (idx_ext + CNT_W'(1) < fill_reg)
                begin
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // load the result word once the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_data_next  = (op_reg == OP_GET && hit_reg) ? save_reg : '0;
                    out_cnt_next   = fill_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            pos_reg       <= '0;
            hit_reg       <= 1'b0;
            fill_reg      <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            hit_reg       <= hit_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        din_reg      <= din_next;
        save_reg     <= save_next;
        out_hit_reg  <= out_hit_next;
        out_data_reg <= out_data_next;
        out_cnt_reg  <= out_cnt_next;
    end

    // result word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_cnt_reg, out_data_reg};

endmodule

// ===== dv/lru_move_to_front_cache_tb.sv =====
// self-checking testbench for the move-to-front lru cache
// depends on lru_mtf_pkg and lru_move_to_front_cache, which also needs lru_mtf_ram
// directed table first, then random phases over several capacity settings
module lru_move_to_front_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lru_mtf_pkg::*;

    // expected result of one word
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] dout;
        logic [CNT_W-1:0]  held;
    } cache_reply_t;

    // one row of directed stimulus; typed answer used when fixed is set
    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] din;
        logic              fixed;
        logic              hit;
        logic [DATA_W-1:0] dout;
        logic [CNT_W-1:0]  held;
    } dir_row_t;

    localparam logic [DATA_W-1:0] ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] A5   = 64'hA5A5_5A5A_0F0F_F0F0;
    localparam logic [DATA_W-1:0] ZERO = '0;
    localparam int DIR_ROWS = 21;
    localparam int RAND_PER_PHASE = 160;
    localparam int PHASES = 9;
    localparam int SETTLE = 100;

    // directed rows, run at capacity 3 so that eviction is reached early
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{OP_GET,   32'h0000_0000, ZERO, 1'b1, 1'b0, ZERO, 5'd0},  // empty list
        '{OP_PUT,   32'h0000_0000, ZERO, 1'b1, 1'b0, ZERO, 5'd1},
        '{OP_PUT,   32'hFFFF_FFFF, ONES, 1'b1, 1'b0, ZERO, 5'd2},
        '{OP_GET,   32'hFFFF_FFFF, ZERO, 1'b1, 1'b1, ONES, 5'd2},
        '{OP_GET,   32'h0000_0000, ONES, 1'b1, 1'b1, ZERO, 5'd2},
        '{OP_PUT,   32'h0000_0000, A5,   1'b1, 1'b1, ZERO, 5'd2},  // update keeps count
        '{OP_GET,   32'h0000_0000, ZERO, 1'b1, 1'b1, A5,   5'd2},
        '{OP_PUT,   32'h0000_0001, 64'd1, 1'b1, 1'b0, ZERO, 5'd3},
        '{OP_PUT,   32'h0000_0002, 64'd2, 1'b1, 1'b0, ZERO, 5'd3}, // evicts all-ones key
        '{OP_GET,   32'hFFFF_FFFF, ZERO, 1'b1, 1'b0, ZERO, 5'd3},
        '{OP_GET,   32'h0000_0000, ZERO, 1'b1, 1'b1, A5,   5'd3},  // deepest slot
        '{OP_INVAL, 32'h0000_0005, ZERO, 1'b1, 1'b0, ZERO, 5'd3},
        '{OP_INVAL, 32'h0000_0001, ZERO, 1'b1, 1'b1, ZERO, 5'd2},  // last entry, so no gap to close
        '{OP_GET,   32'h0000_0000, ZERO, 1'b1, 1'b1, A5,   5'd2},
        '{OP_GET,   32'h0000_0002, ZERO, 1'b1, 1'b1, 64'd2, 5'd2},
        '{OP_CLEAR, 32'h0000_0002, ONES, 1'b1, 1'b1, ZERO, 5'd0},  // clear reports hit
        '{OP_CLEAR, 32'h0000_0000, ZERO, 1'b1, 1'b0, ZERO, 5'd0},
        '{OP_GET,   32'h0000_0002, ZERO, 1'b1, 1'b0, ZERO, 5'd0},
        '{OP_PUT,   32'h8000_0000, 64'h8000_0000_0000_0000, 1'b0, 1'b0, ZERO, 5'd0},
        '{OP_PUT,   32'h1234_5678, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, ZERO, 5'd0},
        '{OP_INVAL, 32'h8000_0000, ZERO, 1'b0, 1'b0, ZERO, 5'd0}
    };

    // capacity settings for the random phases, out of range values included
    localparam logic [CNT_W-1:0] CAP_PLAN [PHASES] = '{
        5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd7, 5'd2, 5'd16, 5'd12
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CNT_W-1:0]       cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    // predictor state: recency list, front at index 0
    logic [KEY_W-1:0]  lru_keys  [DEPTH];
    logic [DATA_W-1:0] lru_data  [DEPTH];
    logic              lru_valid [DEPTH];
    int                lru_fill;
    logic [CNT_W-1:0]  lru_cap;

    cache_reply_t pending_replies [$];
    int mismatch_count = 0;
    int words_sent = 0;
    int replies_checked = 0;
    int hits_seen = 0;
    bit quiet_run = 1'b0;

    lru_move_to_front_cache dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // apply one operation to the predictor and return its answer
    function automatic cache_reply_t cache_lookup_update(op_t op, logic [KEY_W-1:0] key,
                                                         logic [DATA_W-1:0] din);
        cache_reply_t r;
        int pos;
        int eff;
        logic [KEY_W-1:0] k_keep;
        logic [DATA_W-1:0] d_keep;
        r = '0;
        pos = 0;
        for (int i = 0; i < lru_fill; i++)
        begin
            if (!r.hit && lru_valid[i] && lru_keys[i] == key)
            begin
                r.hit = 1'b1;
                pos = i;
            end
        end
        // get and put hits bring the entry to the front
        if ((op == OP_GET || op == OP_PUT) && r.hit)
        begin
            k_keep = lru_keys[pos];
            d_keep = lru_data[pos];
            for (int i = pos; i > 0; i--)
            begin
                lru_keys[i] = lru_keys[i-1];
                lru_data[i] = lru_data[i-1];
            end
            lru_keys[0] = k_keep;
            lru_data[0] = (op == OP_PUT) ? din : d_keep;
            if (op == OP_GET)
                r.dout = d_keep;
        end
        else if (op == OP_PUT)
        begin
            // miss: trim to capacity-1, shift down, insert at the front
            eff = (lru_cap == 0) ? 1 : (lru_cap > DEPTH) ? DEPTH : int'(lru_cap);
            if (lru_fill >= eff)
            begin
                for (int i = eff - 1; i < lru_fill; i++)
                    lru_valid[i] = 1'b0;
                lru_fill = eff - 1;
            end
            for (int i = lru_fill; i > 0; i--)
            begin
                lru_keys[i]  = lru_keys[i-1];
                lru_data[i]  = lru_data[i-1];
                lru_valid[i] = lru_valid[i-1];
            end
            lru_keys[0]  = key;
            lru_data[0]  = din;
            lru_valid[0] = 1'b1;
            lru_fill++;
        end
        else if (op == OP_INVAL && r.hit)
        begin
            for (int i = pos; i + 1 < lru_fill; i++)
            begin
                lru_keys[i]  = lru_keys[i+1];
                lru_data[i]  = lru_data[i+1];
                lru_valid[i] = lru_valid[i+1];
            end
            lru_fill--;
            lru_valid[lru_fill] = 1'b0;
        end
        else if (op == OP_CLEAR)
        begin
            for (int i = 0; i < DEPTH; i++)
                lru_valid[i] = 1'b0;
            lru_fill = 0;
        end
        r.held = CNT_W'(lru_fill);
        return r;
    endfunction

    // offer one word after a random gap, or none on a quiet run; called and left at a falling edge
    task automatic send_word(op_t op, logic [KEY_W-1:0] key, logic [DATA_W-1:0] din,
                             bit fixed, cache_reply_t typed);
        int gap;
        cache_reply_t r;
        gap = quiet_run ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {din, key};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = cache_lookup_update(op, key, din);
        pending_replies.push_back(fixed ? typed : r);
        words_sent++;
        @(negedge clk);
    endtask

    // let every result drain, then write the capacity register
    task automatic set_capacity(logic [CNT_W-1:0] cap);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        lru_cap = cap;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // result side: random stalls except on quiet runs, compare each word with the oldest prediction
    initial
    begin
        cache_reply_t want;
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = quiet_run ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            replies_checked++;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: result word with nothing expected: hit %b data %h held %0d",
                         $time, m_axis_tuser, m_axis_tdata[DATA_W-1:0],
                         m_axis_tdata[DATA_W +: CNT_W]);
                mismatch_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (want.hit)
                    hits_seen++;
                if (m_axis_tuser !== want.hit)
                begin
                    $display("%0t: hit expected %b got %b", $time, want.hit, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tdata[DATA_W-1:0] !== want.dout)
                begin
                    $display("%0t: data_out expected %h got %h", $time, want.dout,
                             m_axis_tdata[DATA_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[DATA_W +: CNT_W] !== want.held)
                begin
                    $display("%0t: entries_held expected %0d got %0d", $time, want.held,
                             m_axis_tdata[DATA_W +: CNT_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [KEY_W-1:0] key_pool [32];
        logic [KEY_W-1:0] key;
        int pool_n;
        int pick;
        op_t op;
        cache_reply_t typed;

        for (int i = 0; i < DEPTH; i++)
        begin
            lru_keys[i]  = '0;
            lru_data[i]  = '0;
            lru_valid[i] = 1'b0;
        end
        lru_fill = 0;
        lru_cap  = CAP_RESET;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        set_capacity(5'd3);
        for (int n = 0; n < DIR_ROWS; n++)
        begin
            typed.hit  = DIR_TAB[n].hit;
            typed.dout = DIR_TAB[n].dout;
            typed.held = DIR_TAB[n].held;
            send_word(DIR_TAB[n].op, DIR_TAB[n].key, DIR_TAB[n].din, DIR_TAB[n].fixed, typed);
        end

        // random phases; the list is kept across capacity changes
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_capacity(CAP_PLAN[ph]);
            quiet_run = (ph % 3 == 2);
            pool_n = $urandom_range(2, 28);
            for (int i = 0; i < pool_n; i++)
                key_pool[i] = $urandom;
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    op = OP_GET;
                else if (pick < 78)
                    op = OP_PUT;
                else if (pick < 97)
                    op = OP_INVAL;
                else
                    op = OP_CLEAR;
                key = ($urandom_range(0, 9) == 0) ? $urandom
                                                  : key_pool[$urandom_range(0, pool_n - 1)];
                send_word(op, key, {$urandom, $urandom}, 1'b0, '0);
                // hold off mid-phase once until every result is back
                if (ph == 4 && n == RAND_PER_PHASE / 2)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_replies.size() != 0)
                        @(negedge clk);
                end
            end
        end

        // drain and finish
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("%0d words sent, %0d results checked, %0d hits, %0d capacity settings",
                 words_sent, replies_checked, hits_seen, PHASES + 1);
        if (mismatch_count == 0)
            $display("lru_move_to_front_cache_tb: clean");
        else
            $display("lru_move_to_front_cache_tb: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", pending_replies.size());
        $display("lru_move_to_front_cache_tb: errors");
        $finish;
    end

endmodule
